// ----- design/wcrl_pkg.sv -----
// ---------------------------------------------------------------------------
// wcrl_pkg
// Types and constants shared by the windowed category rate limiter.
// ---------------------------------------------------------------------------
package wcrl_pkg;

    // field widths
    localparam int TIME_W     = 64;
    localparam int OP_W       = 16;
    localparam int LEN_W      = 40;
    localparam int CAP_W      = 16;
    localparam int SUP_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // category field of the operation code
    localparam int CAT_LSB = 8;
    localparam int CAT_W   = 4;

    // default category count
    localparam int NUM_CATEGORIES_DEF = 16;

    // register reset values
    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = LEN_W'(64'd1000000000);
    localparam logic [CAP_W-1:0] TOTAL_CAP_RST     = CAP_W'(16'd100);
    localparam logic [CAP_W-1:0] CATEGORY_CAP_RST  = CAP_W'(16'd10);

    // saturation value of the suppressed count
    localparam logic [SUP_W-1:0] SUP_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CATEGORY_CAP  = 2'd2;

    // input word
    typedef struct packed {
        logic [TIME_W-1:0] event_time_ns;
        logic [OP_W-1:0]   op_code;
    } t_in_word;

    // result word
    typedef struct packed {
        logic              passed;
        logic              window_restarted;
        logic [SUP_W-1:0]  ended_window_suppressed;
        logic [SUP_W-1:0]  suppressed_so_far;
    } t_out_word;

endpackage

// ----- design/windowed_category_rate_limiter_unit.sv -----
// An accepted event goes to the input register, then its result to the result register.
// Throughput: one event per cycle unless stalled; compare and update are combinational.
// Reset (i_rst_n low, synchronous): counters, window start, valid flags cleared,
//   registers back to window 1000000000 ns, total cap 100, category cap 10.
// Config port is always ready; write only while no event is in flight.
// ---------------------------------------------------------------------------
// windowed_category_rate_limiter_unit
// Fixed-window event rate limiter with a total cap and a per-category cap.
// ---------------------------------------------------------------------------
module windowed_category_rate_limiter_unit #(
    parameter int NUM_CATEGORIES = wcrl_pkg::NUM_CATEGORIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // event input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wcrl_pkg::t_in_word                  i_in_word,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wcrl_pkg::t_out_word                 o_out_word,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wcrl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
    localparam int CMP_W = wcrl_pkg::CAT_W + 1;
    localparam logic [CMP_W-1:0] NUM_CAT_C = CMP_W'(NUM_CATEGORIES);
    localparam logic [CMP_W-1:0] LAST_CAT  = CMP_W'(NUM_CATEGORIES - 1);

    // configuration registers
    logic [wcrl_pkg::LEN_W-1:0] r_window_length;
    logic [wcrl_pkg::CAP_W-1:0] r_total_cap;
    logic [wcrl_pkg::CAP_W-1:0] r_category_cap;

    // window state
    logic [wcrl_pkg::TIME_W-1:0] r_window_start;
    logic [wcrl_pkg::CAP_W-1:0]  r_cat_cnt [NUM_CATEGORIES];
    logic [wcrl_pkg::CAP_W-1:0]  r_total_passed;
    logic [wcrl_pkg::SUP_W-1:0]  r_sup;

    // pipeline registers
    logic                 r_s1_valid;
    wcrl_pkg::t_in_word   r_s1_word;
    logic                 r_out_valid;
    wcrl_pkg::t_out_word  r_out_word;

    // handshake
    logic advance;
    logic s1_fire;

    // datapath
    logic [CMP_W-1:0]             cat_raw;
    logic [IDX_W-1:0]             cat_idx;
    logic [wcrl_pkg::TIME_W-1:0]  elapsed;
    logic                         restart;
    logic [wcrl_pkg::CAP_W-1:0]   cat_cur;
    logic [wcrl_pkg::CAP_W-1:0]   tot_cur;
    logic [wcrl_pkg::SUP_W-1:0]   sup_cur;
    logic                         pass;
    logic [wcrl_pkg::SUP_W-1:0]   n_sup;
    wcrl_pkg::t_out_word          n_out_word;

    assign o_cfg_ready = 1'b1;

    // pipeline moves when the result register is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;

    // category select with clamp to the last category
    always_comb begin
        cat_raw = {1'b0, r_s1_word.op_code[wcrl_pkg::CAT_LSB +: wcrl_pkg::CAT_W]};
        if (cat_raw >= NUM_CAT_C) begin
            cat_raw = LAST_CAT;
        end
        cat_idx = cat_raw[IDX_W-1:0];
    end

    // window check, then judge against the caps
    always_comb begin
        elapsed = r_s1_word.event_time_ns - r_window_start;
        restart = elapsed > {{(wcrl_pkg::TIME_W-wcrl_pkg::LEN_W){1'b0}}, r_window_length};
        cat_cur = restart ? '0 : r_cat_cnt[cat_idx];
        tot_cur = restart ? '0 : r_total_passed;
        sup_cur = restart ? '0 : r_sup;
        pass    = (tot_cur < r_total_cap) && (cat_cur < r_category_cap);
        n_sup   = (!pass && sup_cur != wcrl_pkg::SUP_MAX) ? sup_cur + 1'b1 : sup_cur;

        n_out_word.passed                  = pass;
        n_out_word.window_restarted        = restart;
        n_out_word.ended_window_suppressed = restart ? r_sup : '0;
        n_out_word.suppressed_so_far       = n_sup;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= wcrl_pkg::WINDOW_LENGTH_RST;
            r_total_cap     <= wcrl_pkg::TOTAL_CAP_RST;
            r_category_cap  <= wcrl_pkg::CATEGORY_CAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wcrl_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= i_cfg_data[wcrl_pkg::LEN_W-1:0];
                end
                wcrl_pkg::REG_TOTAL_CAP: begin
                    r_total_cap <= i_cfg_data[wcrl_pkg::CAP_W-1:0];
                end
                wcrl_pkg::REG_CATEGORY_CAP: begin
                    r_category_cap <= i_cfg_data[wcrl_pkg::CAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // window state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
            r_total_passed <= '0;
            r_sup          <= '0;
            for (int i = 0; i < NUM_CATEGORIES; i++) begin
                r_cat_cnt[i] <= '0;
            end
        end else if (s1_fire) begin
            if (restart) begin
                r_window_start <= r_s1_word.event_time_ns;
            end
            // a restart clears every category; the judged one may count up
            for (int i = 0; i < NUM_CATEGORIES; i++) begin
                if (pass && cat_idx == IDX_W'(i)) begin
                    r_cat_cnt[i] <= cat_cur + 1'b1;
                end else if (restart) begin
                    r_cat_cnt[i] <= '0;
                end
            end
            if (pass) begin
                r_total_passed <= tot_cur + 1'b1;
            end else begin
                r_total_passed <= tot_cur;
            end
            r_sup <= n_sup;
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
        if (s1_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    // the ended-window count is only reported on a restart
    a_ended_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.window_restarted)
            |-> (r_out_word.ended_window_suppressed == '0))
        else $error("ended window count without restart");

    // the held result reflects the live suppressed count
    a_sup_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.suppressed_so_far == r_sup))
        else $error("result suppressed count out of step with state");

    // a passed event inside the window leaves the suppressed count alone
    a_pass_keeps_sup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && pass && !restart) |=> (r_sup == $past(r_sup)))
        else $error("suppressed count moved on a passed event");

    // a restart leaves at most one pass in the new window
    a_restart_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && restart) |=> (r_total_passed <= 16'd1))
        else $error("total count not cleared on window restart");
`endif

endmodule
